// ===== rtl/core/hll_pkg.sv =====
// Package for the HyperLogLog cardinality sketch.
// Holds the fixed field widths, reset values and fixed-point constants.
// No dependencies.
package hll_pkg;

   localparam int unsigned HASH_W = 64;
   localparam int unsigned CARD_W = 64;
   localparam int unsigned CFG_W  = 4;
   localparam int unsigned RANK_W = 7;
   localparam int unsigned NUM_W  = 96;

   localparam logic [CFG_W-1:0] INDEX_BITS_RST = 4'd10;

   localparam logic [26:0] LN2_Q27 = 27'h58B90BF;

   localparam logic [63:0] ALPHA_N4  = (64'd673 << 32) / 64'd1000;
   localparam logic [63:0] ALPHA_N6  = (64'd697 << 32) / 64'd1000;
   localparam logic [63:0] ALPHA_N8  = (64'd709 << 32) / 64'd1000;
   localparam logic [63:0] ALPHA_N9  = (64'd7213 << 41) / ((64'd10000 << 9) + 64'd10790);
   localparam logic [63:0] ALPHA_N10 = (64'd7213 << 42) / ((64'd10000 << 10) + 64'd10790);
   localparam logic [63:0] ALPHA_N11 = (64'd7213 << 43) / ((64'd10000 << 11) + 64'd10790);
   localparam logic [63:0] ALPHA_N12 = (64'd7213 << 44) / ((64'd10000 << 12) + 64'd10790);
   localparam logic [63:0] ALPHA_N13 = (64'd7213 << 45) / ((64'd10000 << 13) + 64'd10790);
   localparam logic [63:0] ALPHA_N14 = (64'd7213 << 46) / ((64'd10000 << 14) + 64'd10790);
   localparam logic [63:0] ALPHA_N15 = (64'd7213 << 47) / ((64'd10000 << 15) + 64'd10790);
   localparam logic [63:0] ALPHA_N16 = (64'd7213 << 48) / ((64'd10000 << 16) + 64'd10790);

   // Bias correction in Q32 for a given index width.
   function automatic logic [31:0] alpha_q(input logic [4:0] n);
      logic [31:0] a;
      case (n)
         5'd1, 5'd2, 5'd3, 5'd4: a = ALPHA_N4[31:0];
         5'd5, 5'd6:             a = ALPHA_N6[31:0];
         5'd7, 5'd8:             a = ALPHA_N8[31:0];
         5'd9:                   a = ALPHA_N9[31:0];
         5'd10:                  a = ALPHA_N10[31:0];
         5'd11:                  a = ALPHA_N11[31:0];
         5'd12:                  a = ALPHA_N12[31:0];
         5'd13:                  a = ALPHA_N13[31:0];
         5'd14:                  a = ALPHA_N14[31:0];
         5'd15:                  a = ALPHA_N15[31:0];
         default:                a = ALPHA_N16[31:0];
      endcase
      return a;
   endfunction

endpackage

// ===== rtl/core/hll_cardinality_sketch.sv =====
// HyperLogLog distinct-count sketch, top level with the item sequencer.
// Depends on hll_pkg, hll_ram, hll_div and hll_lin.
//
// Usage: each item on the req_ channel carries a 64-bit hash; it is taken
// when req_valid is high and req_stall is low. For every item one estimate
// leaves on the rsp_ channel, taken when rsp_valid is high and rsp_stall is
// low. The csr_ channel writes index_bits; it is always ready and should be
// written only while the block is idle.
// Per item: acceptance in S_IDLE, the rank scan, the bucket update, a sweep
// of all m = 2^n buckets through the RAM read port, the compare states S_CMP1
// and S_CMP2, then either the divider or the linear-count unit, and the load of
// the output register once it is free.
// After reset the bucket RAM is cleared, one entry a cycle, over all
// 2^MAX_INDEX_BITS entries with req_stall high; index_bits returns to 10.
// A finished estimate waits in the output register while the receiver
// stalls; the next item can be accepted and worked on meanwhile, and it waits
// before its own result until the register is free.
module hll_cardinality_sketch #(
   parameter int unsigned MAX_INDEX_BITS = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [hll_pkg::CFG_W-1:0]  csr_index_bits,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [hll_pkg::HASH_W-1:0] req_hash_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [hll_pkg::CARD_W-1:0] rsp_cardinality
);

   localparam int unsigned DEPTH  = 1 << MAX_INDEX_BITS;
   localparam int unsigned AW     = MAX_INDEX_BITS;
   localparam int unsigned CNT_W  = MAX_INDEX_BITS + 1;
   localparam int unsigned S_W    = 65 + MAX_INDEX_BITS;
   localparam int unsigned SUM5_W = S_W + 3;
   localparam int unsigned RHS_W  = SUM5_W + MAX_INDEX_BITS;
   localparam int unsigned CMP_W  = (RHS_W > 97) ? RHS_W : 97;
   localparam int unsigned RW     = hll_pkg::RANK_W;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_RANK, S_UPDATE, S_SWEEP, S_CMP1, S_CMP2, S_DIV, S_LIN, S_HOLD
   } seq_state_type;

   seq_state_type            state_ff;
   logic [hll_pkg::CFG_W-1:0] index_bits_ff;
   logic [AW-1:0]            clr_cnt_ff;
   logic [4:0]               n_ff;
   logic [63:0]              rem_ff;
   logic [RW-1:0]            rank_ff;
   logic [AW-1:0]            idx_ff;
   logic [CNT_W-1:0]         swp_cnt_ff;
   logic                     pend_ff;
   logic [S_W-1:0]           s_ff;
   logic [CNT_W-1:0]         zeros_ff;
   logic [SUM5_W-1:0]        sum5_ff;
   logic [63:0]              p_ff;
   logic [63:0]              res_ff;
   logic                     rsp_valid_ff;
   logic [63:0]              rsp_card_ff;

   logic [4:0]    n_eff;
   logic [63:0]   idx_full;
   logic          req_acc;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [RW-1:0] wr_data;
   logic [AW-1:0] rd_addr;
   logic [RW-1:0] rd_data;
   logic [CNT_W-1:0] m_cnt;
   logic [S_W-1:0]   term;
   logic [CMP_W-1:0] lhs;
   logic [CMP_W-1:0] rhs;
   logic          use_lin;
   logic          div_start;
   logic          lin_start;
   logic          div_done;
   logic          lin_done;
   logic [63:0]   div_quot;
   logic [63:0]   lin_res;

   always_comb begin
      if (index_bits_ff == '0) begin
         n_eff = 5'd1;
      end else if ({1'b0, index_bits_ff} > 5'(MAX_INDEX_BITS)) begin
         n_eff = 5'(MAX_INDEX_BITS);
      end else begin
         n_eff = {1'b0, index_bits_ff};
      end
      idx_full = req_hash_value >> (7'd64 - {2'd0, n_eff});
      req_acc  = (state_ff == S_IDLE) && req_valid;
      wr_en    = (state_ff == S_CLEAR) || ((state_ff == S_UPDATE) && (rank_ff > rd_data));
      wr_addr  = (state_ff == S_CLEAR) ? clr_cnt_ff : idx_ff;
      wr_data  = (state_ff == S_CLEAR) ? '0 : rank_ff;
      rd_addr  = (state_ff == S_SWEEP) ? swp_cnt_ff[AW-1:0] : idx_ff;
      m_cnt    = CNT_W'(1) << n_ff;
      term     = S_W'(1) << (7'd64 - rd_data);
      lhs      = CMP_W'({p_ff, 33'd0});
      rhs      = CMP_W'(sum5_ff) << n_ff;
      use_lin  = (rhs >= lhs) && (zeros_ff != '0);
      div_start = (state_ff == S_CMP2) && !use_lin;
      lin_start = (state_ff == S_CMP2) && use_lin;
   end

   hll_ram #(
      .WIDTH (RW),
      .DEPTH (DEPTH)
   ) u_bucket_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   hll_div #(
      .DEN_W (S_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   ({p_ff, 32'd0}),
      .den   (s_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   hll_lin #(
      .Z_W (CNT_W)
   ) u_lin (
      .clock  (clock),
      .reset  (reset),
      .start  (lin_start),
      .n      (n_ff),
      .zeros  (zeros_ff),
      .done   (lin_done),
      .result (lin_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         index_bits_ff <= hll_pkg::INDEX_BITS_RST;
         clr_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            index_bits_ff <= csr_index_bits;
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == AW'(DEPTH - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_acc) begin
                  n_ff     <= n_eff;
                  rem_ff   <= req_hash_value << n_eff;
                  idx_ff   <= idx_full[AW-1:0];
                  rank_ff  <= RW'(1);
                  state_ff <= S_RANK;
               end
            end
            S_RANK: begin
               if ((rem_ff == '0) || rem_ff[63]) begin
                  state_ff <= S_UPDATE;
               end else begin
                  rem_ff  <= {rem_ff[62:0], 1'b0};
                  rank_ff <= rank_ff + 1'b1;
               end
            end
            S_UPDATE: begin
               swp_cnt_ff <= '0;
               pend_ff    <= 1'b0;
               s_ff       <= '0;
               zeros_ff   <= '0;
               state_ff   <= S_SWEEP;
            end
            S_SWEEP: begin
               pend_ff <= (swp_cnt_ff != m_cnt);
               if (swp_cnt_ff != m_cnt) begin
                  swp_cnt_ff <= swp_cnt_ff + 1'b1;
               end
               if (pend_ff) begin
                  s_ff <= s_ff + term;
                  if (rd_data == '0) begin
                     zeros_ff <= zeros_ff + 1'b1;
                  end
               end
               if ((swp_cnt_ff == m_cnt) && !pend_ff) begin
                  state_ff <= S_CMP1;
               end
            end
            S_CMP1: begin
               sum5_ff  <= SUM5_W'({s_ff, 2'b00}) + SUM5_W'(s_ff);
               p_ff     <= {32'd0, hll_pkg::alpha_q(n_ff)} << {n_ff, 1'b0};
               state_ff <= S_CMP2;
            end
            S_CMP2: begin
               state_ff <= use_lin ? S_LIN : S_DIV;
            end
            S_DIV: begin
               if (div_done) begin
                  res_ff   <= div_quot;
                  state_ff <= S_HOLD;
               end
            end
            S_LIN: begin
               if (lin_done) begin
                  res_ff   <= lin_res;
                  state_ff <= S_HOLD;
               end
            end
            S_HOLD: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_card_ff  <= res_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign csr_ready       = 1'b1;
   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cardinality = rsp_card_ff;

   a_rsp_from_hold: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_HOLD))
      else $error("Result appeared without a finished estimate.");

   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_CLEAR) || (state_ff == S_UPDATE))
      else $error("Bucket RAM written outside clear or update.");

   a_rank_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE) |-> (rank_ff != '0) && (rank_ff <= RW'(64)))
      else $error("Rank out of range at bucket update.");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_RANK))
      else $error("Accepted item did not start the rank scan.");

   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      !(div_start && lin_start))
      else $error("Both estimate units started together.");

endmodule

// ===== rtl/core/hll_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hll_ram #(
   parameter int unsigned WIDTH = 7,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/hll_div.sv =====
// Restoring divider, one quotient bit per cycle, saturating to 64 bits.
// Depends on hll_pkg.
module hll_div #(
   parameter int unsigned DEN_W = 75
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [hll_pkg::NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]           den,
   output logic                       done,
   output logic [hll_pkg::CARD_W-1:0] quot
);

   localparam int unsigned NW    = hll_pkg::NUM_W;
   localparam int unsigned CNT_W = $clog2(NW);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NW-1:0]    q_ff;
   logic [DEN_W-1:0] r_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0]   r_sh;
   logic [DEN_W:0]   diff;
   logic             fits;
   logic [DEN_W-1:0] r_in;

   always_comb begin
      r_sh = {r_ff, q_ff[NW-1]};
      diff = r_sh - {1'b0, den_ff};
      fits = (r_sh >= {1'b0, den_ff});
      r_in = fits ? diff[DEN_W-1:0] : r_sh[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == CNT_W'(NW - 1))) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff <= '0;
         q_ff   <= num;
         r_ff   <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         q_ff   <= {q_ff[NW-2:0], fits};
         r_ff   <= r_in;
      end
   end

   assign done = done_ff;
   assign quot = (|q_ff[NW-1:hll_pkg::CARD_W]) ? '1 : q_ff[hll_pkg::CARD_W-1:0];

endmodule

// ===== rtl/core/hll_lin.sv =====
// Linear-counting estimate m*ln(m/z): normalize z, log2 by repeated squaring
// on one shared 32x32 multiplier, then scale by ln2. Depends on hll_pkg.
module hll_lin #(
   parameter int unsigned Z_W = 11
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [4:0]                 n,
   input  logic [Z_W-1:0]             zeros,
   output logic                       done,
   output logic [hll_pkg::CARD_W-1:0] result
);

   typedef enum logic [2:0] {
      L_IDLE, L_NORM, L_MUL, L_FIX, L_FIN1, L_FIN2, L_FIN3
   } lin_state_type;

   lin_state_type state_ff;
   logic          done_ff;
   logic [31:0]   x_ff;
   logic [4:0]    c_ff;
   logic [4:0]    k_ff;
   logic [31:0]   frac_ff;
   logic [63:0]   prod_ff;
   logic [63:0]   neg_ff;
   logic [4:0]    n_ff;
   logic [63:0]   res_ff;

   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] mul_p;
   logic [5:0]  ne;
   logic [33:0] t;
   logic [63:0] diff;
   logic [5:0]  sh;

   always_comb begin
      ne = 6'(n_ff) + 6'(c_ff) - 6'd30;
      t  = prod_ff[63:30];
      diff = {prod_ff[31:0], 32'd0} - neg_ff;
      sh = 6'd59 - 6'(n_ff);
      case (state_ff)
         L_MUL: begin
            mul_a = x_ff;
            mul_b = x_ff;
         end
         L_FIN1: begin
            mul_a = frac_ff;
            mul_b = {5'd0, hll_pkg::LN2_Q27};
         end
         L_FIN2: begin
            mul_a = {26'd0, ne};
            mul_b = {5'd0, hll_pkg::LN2_Q27};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            L_IDLE: begin
               if (start) begin
                  x_ff     <= 32'(zeros);
                  c_ff     <= '0;
                  n_ff     <= n;
                  state_ff <= L_NORM;
               end
            end
            L_NORM: begin
               if (x_ff[30]) begin
                  k_ff     <= '0;
                  frac_ff  <= '0;
                  state_ff <= L_MUL;
               end else begin
                  x_ff <= {x_ff[30:0], 1'b0};
                  c_ff <= c_ff + 1'b1;
               end
            end
            L_MUL: begin
               prod_ff  <= mul_p;
               state_ff <= L_FIX;
            end
            L_FIX: begin
               if (t[31]) begin
                  x_ff    <= t[32:1];
                  frac_ff <= {frac_ff[30:0], 1'b1};
               end else begin
                  x_ff    <= t[31:0];
                  frac_ff <= {frac_ff[30:0], 1'b0};
               end
               k_ff <= k_ff + 1'b1;
               state_ff <= (k_ff == 5'd31) ? L_FIN1 : L_MUL;
            end
            L_FIN1: begin
               prod_ff  <= mul_p;
               state_ff <= L_FIN2;
            end
            L_FIN2: begin
               neg_ff   <= prod_ff;
               prod_ff  <= mul_p;
               state_ff <= L_FIN3;
            end
            L_FIN3: begin
               res_ff   <= diff >> sh;
               done_ff  <= 1'b1;
               state_ff <= L_IDLE;
            end
            default: begin
               state_ff <= L_IDLE;
            end
         endcase
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

// ===== verif/hll_estimate_checker.sv =====
`timescale 1ns / 100ps
// Checker for the HyperLogLog sketch: watches the csr_, req_ and rsp_ channels,
// keeps its own copy of the buckets and index width, and compares every estimate.
// Depends on hll_pkg for the field widths and the index-width reset value.
module hll_estimate_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [hll_pkg::CFG_W-1:0]  csr_index_bits,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [hll_pkg::HASH_W-1:0] req_hash_value,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [hll_pkg::CARD_W-1:0] rsp_cardinality,
   output int                         failures,
   output int                         pending,
   output int                         results_seen
);
   localparam int unsigned DEPTH = 1024;
   localparam logic [63:0] LN2_FIX = 64'hB17217F7 >> 5;

   logic [hll_pkg::RANK_W-1:0] ranks [DEPTH];
   logic [hll_pkg::CFG_W-1:0]  width_reg;
   logic [63:0]                cardinality_q [$];

   function automatic int unsigned count_lead_zeros(input logic [63:0] v);
      int unsigned c;
      c = 0;
      while (c < 64 && !v[63-c]) c++;
      return c;
   endfunction

   function automatic logic [63:0] linear_estimate(input int unsigned n,
                                                   input logic [63:0] z);
      int unsigned e;
      logic [63:0] x, frac, lval, prod;
      e = 63 - count_lead_zeros(z);
      x = z << (30 - e);
      frac = 0;
      for (int k = 0; k < 32; k++) begin
         x = (x * x) >> 30;
         frac = frac << 1;
         if (x >= (64'd2 << 30)) begin
            x = x >> 1;
            frac[0] = 1'b1;
         end
      end
      lval = (64'(n - e) << 32) - frac;
      prod = lval * LN2_FIX;
      return prod >> (59 - n);
   endfunction

   function automatic logic [63:0] predict_cardinality(input logic [63:0] h);
      int unsigned n, rank, idx;
      logic [63:0] m, alpha, zeros, p, rem;
      logic [127:0] s, num, lhs, rhs, q;
      n = (width_reg < 1) ? 1 : (width_reg > 10) ? 10 : width_reg;
      idx = 32'((h >> (64 - n)) & 64'(DEPTH - 1));
      rem = h << n;
      rank = (rem == 0) ? 1 : 1 + count_lead_zeros(rem);
      if (rank > ranks[idx]) ranks[idx] = rank[6:0];
      m = 64'd1 << n;
      if (n <= 4) alpha = (64'd673 << 32) / 64'd1000;
      else if (n <= 6) alpha = (64'd697 << 32) / 64'd1000;
      else if (n <= 8) alpha = (64'd709 << 32) / 64'd1000;
      else alpha = ((64'd7213 << 32) * m) / (64'd10000 * m + 64'd10790);
      s = 0;
      zeros = 0;
      for (int i = 0; i < m; i++) begin
         if (ranks[i] == 0) begin
            zeros++;
            s = s + (128'd1 << 64);
         end else begin
            s = s + (128'd1 << (64 - ranks[i]));
         end
      end
      p = alpha * m * m;
      num = {32'd0, p, 32'd0};
      lhs = num << 1;
      rhs = ((s << 2) + s) << n;
      if (rhs >= lhs && zeros > 0) return linear_estimate(n, zeros);
      q = num / s;
      return (q[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
   endfunction

   assign pending = cardinality_q.size();

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) ranks[i] = '0;
         width_reg = hll_pkg::INDEX_BITS_RST;
         cardinality_q.delete();
         failures <= 0;
         results_seen <= 0;
      end else begin
         if (csr_valid && csr_ready) width_reg = csr_index_bits;
         if (req_valid && !req_stall) cardinality_q.push_back(predict_cardinality(req_hash_value));
         if (rsp_valid && !rsp_stall) begin
            results_seen <= results_seen + 1;
            if (cardinality_q.size() == 0) begin
               $error("cardinality: unexpected item, got %0d", rsp_cardinality);
               failures <= failures + 1;
            end else if (cardinality_q[0] !== rsp_cardinality) begin
               $error("cardinality: expected %0d, got %0d", cardinality_q[0], rsp_cardinality);
               failures <= failures + 1;
               void'(cardinality_q.pop_front());
            end else begin
               void'(cardinality_q.pop_front());
            end
         end
      end
   end
endmodule

// ===== verif/hll_cardinality_sketch_test.sv =====
`timescale 1ns / 100ps
// Top of the sketch testbench: clock, reset, hash stimulus, receiver stalls and
// index width changes; the verdict comes from hll_estimate_checker.
// Depends on hll_pkg, hll_cardinality_sketch and hll_estimate_checker.
module hll_cardinality_sketch_test;
   logic                       clock;
   logic                       reset;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [hll_pkg::CFG_W-1:0]  csr_index_bits;
   logic                       req_valid;
   logic                       req_stall;
   logic [hll_pkg::HASH_W-1:0] req_hash_value;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [hll_pkg::CARD_W-1:0] rsp_cardinality;
   int                         failures;
   int                         pending;
   int                         results_seen;
   bit                         quiet;
   int unsigned                cur_width;
   int unsigned                items_sent;

   hll_cardinality_sketch dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index_bits(csr_index_bits),
      .req_valid(req_valid), .req_stall(req_stall), .req_hash_value(req_hash_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_cardinality(rsp_cardinality)
   );

   hll_estimate_checker u_checker (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index_bits(csr_index_bits),
      .req_valid(req_valid), .req_stall(req_stall), .req_hash_value(req_hash_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_cardinality(rsp_cardinality),
      .failures(failures), .pending(pending), .results_seen(results_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #60_000_000;
      $display("[hll_cardinality_sketch] ERROR");
      $finish;
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         if (quiet || $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   task automatic send_hash(input logic [63:0] h);
      req_valid <= 1'b1;
      req_hash_value <= h;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (!quiet && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic write_width(input logic [3:0] v);
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (300) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index_bits <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_width = (v < 1) ? 1 : (v > 10) ? 10 : v;
   endtask

   function automatic logic [63:0] random_hash();
      logic [63:0] idx, rem;
      int unsigned k;
      idx = {$urandom, $urandom};
      if ($urandom_range(0, 1)) return idx;
      k = $urandom_range(0, 64);
      rem = (k == 64) ? 64'd0 : ({$urandom, $urandom} >> k);
      return (idx << (64 - cur_width)) | (rem >> cur_width);
   endfunction

   int unsigned widths [15] = '{1, 2, 3, 4, 5, 6, 7, 8, 9, 0, 15, 10, 12, 4, 1};
   int unsigned counts [15] = '{150, 150, 130, 130, 130, 120, 100, 60, 30, 100, 15, 15, 10,
                                150, 100};

   initial begin
      reset = 1'b1;
      quiet = 1'b0;
      csr_valid = 1'b0;
      csr_index_bits = '0;
      req_valid = 1'b0;
      req_hash_value = '0;
      cur_width = 10;
      items_sent = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_hash(64'd0);
      send_hash(64'hFFFF_FFFF_FFFF_FFFF);
      send_hash(64'd1);
      send_hash(64'h8000_0000_0000_0000);
      send_hash(64'h0020_0000_0000_0000);
      send_hash(64'h003F_FFFF_FFFF_FFFF);
      send_hash(64'hFFC0_0000_0000_0001);
      send_hash(64'h5555_5555_5555_5555);
      send_hash(64'hAAAA_AAAA_AAAA_AAAA);
      for (int i = 0; i < 6; i++) send_hash(64'd1 << (10 * i));

      for (int ph = 0; ph < 15; ph++) begin
         write_width(widths[ph]);
         if (cur_width == 1) begin
            send_hash(64'd0);
            send_hash(64'h8000_0000_0000_0000);
            send_hash(64'h7FFF_FFFF_FFFF_FFFF);
         end
         if (ph == 14) quiet = 1'b1;
         for (int i = 0; i < counts[ph]; i++) send_hash(random_hash());
      end
      req_valid <= 1'b0;

      do @(negedge clock); while (pending != 0);
      repeat (300) @(posedge clock);
      $display("Sent %0d hashes over index widths 0 to 15, %0d estimates checked.",
               items_sent, results_seen);
      if (failures == 0) begin
         $display("[hll_cardinality_sketch] OK");
      end else begin
         $display("[hll_cardinality_sketch] ERROR");
      end
      $finish;
   end
endmodule

// ===== hll_cardinality_sketch.f =====
rtl/core/hll_pkg.sv
rtl/core/hll_ram.sv
rtl/core/hll_div.sv
rtl/core/hll_lin.sv
rtl/core/hll_cardinality_sketch.sv
verif/hll_estimate_checker.sv
verif/hll_cardinality_sketch_test.sv
